[rtl/s2cd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2cd_pkg
// Shared widths, calendar constants, reciprocals and types for the
// seconds-to-calendar-date pipeline.
// ============================================================================
package s2cd_pkg;

    // Pipeline shape: stages 1..3 split seconds into days and seconds of day,
    // stages 4..12 run the calendar and time-of-day paths side by side.
    localparam int PIPE_DEPTH  = 12;
    localparam int DATE_FIRST  = 4;
    localparam int DATE_STAGES = PIPE_DEPTH - DATE_FIRST + 1;

    // Field and bus widths.
    localparam int SECS_W      = 32;
    localparam int DAYS_W      = 16;
    localparam int SOD_W       = 17;
    localparam int MINS_W      = 11;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Calendar constants.
    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_MIN = 60;
    localparam int MINS_PER_HR  = 60;
    localparam int EPOCH_DN     = 730119;
    localparam int DAYS_400Y    = 146097;
    localparam int DAYS_100Y    = 36524;
    localparam int DAYS_4Y      = 1461;
    localparam int DAYS_1Y      = 365;
    localparam int MONTH_MUL    = 12;
    localparam int MONTH_ADD    = 373;
    localparam int MONTH_DIV    = 367;
    localparam int MARCH_DOY    = 61;

    // Every day number of the input range lies in the fifth or sixth
    // 400-year cycle, so one compare on the day count picks the cycle.
    localparam int DN_SPLIT    = 5 * DAYS_400Y - EPOCH_DN;
    localparam int DN_OFF_LO   = EPOCH_DN - 4 * DAYS_400Y;
    localparam int YEAR_BASE_LO = 4 * 400;
    localparam int YEAR_BASE_HI = 5 * 400;

    // Index of the last slot in a cycle, and the last 4-year block of a century.
    localparam int CYCLE_LAST  = 4;
    localparam int YR4_LEAP    = 3;
    localparam int N4_LAST     = 24;
    localparam int CENT_LAST   = 3;

    // Floor reciprocals; each estimate is low by at most one and gets one
    // compare-and-subtract correction.
    localparam logic [15:0] DAY_RECIP = 16'((64'd1 << SECS_W) / 64'd86400);
    localparam logic [11:0] SOD_RECIP = 12'((64'd1 << SOD_W) / 64'd60);
    localparam logic [5:0]  MIN_RECIP = 6'((64'd1 << MINS_W) / 64'd60);
    localparam logic [5:0]  Q4Y_RECIP = 6'((64'd1 << 16) / 64'd1461);

    // Output field types.
    typedef logic [11:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_mday;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_minute;
    typedef logic [5:0]  t_second;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_mday  mday;
    } t_date;

    typedef struct packed {
        t_hour   hour;
        t_minute minute;
        t_second second;
    } t_tod;

    typedef logic [DATE_STAGES-1:0] t_date_en;

    // Day of year (from 0) on which a month starts in the month formula,
    // that is (367 * month - 362) / 12.
    function automatic logic [8:0] month_start(input t_month m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd61;
            4'd4:    v = 9'd92;
            4'd5:    v = 9'd122;
            4'd6:    v = 9'd153;
            4'd7:    v = 9'd183;
            4'd8:    v = 9'd214;
            4'd9:    v = 9'd245;
            4'd10:   v = 9'd275;
            4'd11:   v = 9'd306;
            4'd12:   v = 9'd336;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/seconds_to_calendar_date_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// seconds_to_calendar_date_unit
// Converts seconds since 2000-01-01 00:00:00 into Gregorian date and time.
// ============================================================================
// Usage:
//   Slave channel (i_s_*) takes one 32-bit seconds count per request.
//   Master channel (o_m_*) returns one date/time request per input, in order.
//   The pipeline has twelve register stages: a request accepted into the
//   first raises o_m_tvalid when it reaches the last and can leave there
//   when the path is not stalled. Throughput is one request per cycle
//   while i_m_tready is high. The depth is the three-stage day split
//   (reciprocal multiply, back-multiply, one correction) followed by
//   the nine-stage calendar path; the time-of-day divisions use six of those
//   stages and are delayed three more to line up with the date.
//   Each stage keeps a valid bit. When i_m_tready is low, the result holds
//   on the output and earlier stages keep advancing into empty slots, so
//   o_s_tready stays high until every stage holds a request.
//   Reset (i_rst_n low at a clock edge) clears all valid bits; data
//   registers are not cleared. No request is lost or repeated on a stall.
// ============================================================================
module seconds_to_calendar_date_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: seconds requests.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [s2cd_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [31:0] seconds_since_epoch
    // Master side: calendar results.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    output logic [s2cd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import s2cd_pkg::*;

    logic [PIPE_DEPTH:1] r_valid;
    logic [PIPE_DEPTH:1] stage_en;

    // Stage 1..3: split into days and seconds of day.
    logic [47:0]       s1_prod;
    logic [SECS_W-1:0] r1_secs;
    logic [DAYS_W-1:0] r1_dest;
    logic [SECS_W-1:0] r2_secs;
    logic [DAYS_W-1:0] r2_dest;
    logic [31:0]       r2_prod;
    logic [17:0]       s3_diff;
    logic [DAYS_W-1:0] n3_days;
    logic [SOD_W-1:0]  n3_sod;
    logic [DAYS_W-1:0] r3_days;
    logic [SOD_W-1:0]  r3_sod;

    // Stage 4..6: minutes of day and seconds.
    logic [28:0]       s4_prod;
    logic [SOD_W-1:0]  r4_sod;
    logic [MINS_W-1:0] r4_mest;
    logic [SOD_W-1:0]  r5_sod;
    logic [MINS_W-1:0] r5_mest;
    logic [SOD_W-1:0]  r5_p;
    logic [6:0]        s6_diff;
    logic [MINS_W-1:0] n6_mins;
    t_second           n6_sec;
    logic [MINS_W-1:0] r6_mins;
    t_second           r6_sec;

    // Stage 7..9: hour and minute.
    logic [16:0]       s7_prod;
    logic [MINS_W-1:0] r7_mins;
    t_hour             r7_hest;
    t_second           r7_sec;
    logic [MINS_W-1:0] r8_mins;
    t_hour             r8_hest;
    logic [MINS_W-1:0] r8_p;
    t_second           r8_sec;
    logic [6:0]        s9_diff;
    t_tod              n9_tod;
    t_tod              r9_tod;

    // Stage 10..12: align with the calendar path.
    t_tod              r10_tod;
    t_tod              r11_tod;
    t_tod              r12_tod;
    t_date             date_out;

    // ------------------------------------------------------- stage handshake
    // A stage may load when it is empty or when the next stage loads.
    always_comb begin
        stage_en[PIPE_DEPTH] = !r_valid[PIPE_DEPTH] || i_m_tready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[1]) begin
                r_valid[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k - 1];
                end
            end
        end
    end

    assign o_s_tready = stage_en[1];
    assign o_m_tvalid = r_valid[PIPE_DEPTH];

    // ------------------------------------------------------------ stage 1
    // Day estimate from the floor reciprocal of 86400.
    assign s1_prod = 48'(i_s_tdata) * 48'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r1_secs <= i_s_tdata;
            r1_dest <= s1_prod[47:32];
        end
    end

    // ------------------------------------------------------------ stage 2
    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r2_secs <= r1_secs;
            r2_dest <= r1_dest;
            r2_prod <= 32'(r1_dest) * 32'(SECS_PER_DAY);
        end
    end

    // ------------------------------------------------------------ stage 3
    // The estimate is at most one day short.
    always_comb begin
        s3_diff = 18'(r2_secs - r2_prod);
        if (s3_diff >= 18'(SECS_PER_DAY)) begin
            n3_days = r2_dest + 16'd1;
            n3_sod  = 17'(s3_diff - 18'(SECS_PER_DAY));
        end else begin
            n3_days = r2_dest;
            n3_sod  = s3_diff[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r3_days <= n3_days;
            r3_sod  <= n3_sod;
        end
    end

    // ------------------------------------------------------------ stage 4
    assign s4_prod = 29'(r3_sod) * 29'(SOD_RECIP);

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r4_sod  <= r3_sod;
            r4_mest <= s4_prod[27:17];
        end
    end

    // ------------------------------------------------------------ stage 5
    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r5_sod  <= r4_sod;
            r5_mest <= r4_mest;
            r5_p    <= 17'(r4_mest) * 17'(SECS_PER_MIN);
        end
    end

    // ------------------------------------------------------------ stage 6
    always_comb begin
        s6_diff = 7'(r5_sod - r5_p);
        if (s6_diff >= 7'(SECS_PER_MIN)) begin
            n6_mins = r5_mest + 11'd1;
            n6_sec  = 6'(s6_diff - 7'(SECS_PER_MIN));
        end else begin
            n6_mins = r5_mest;
            n6_sec  = s6_diff[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r6_mins <= n6_mins;
            r6_sec  <= n6_sec;
        end
    end

    // ------------------------------------------------------------ stage 7
    assign s7_prod = 17'(r6_mins) * 17'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r7_mins <= r6_mins;
            r7_hest <= s7_prod[15:11];
            r7_sec  <= r6_sec;
        end
    end

    // ------------------------------------------------------------ stage 8
    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            r8_mins <= r7_mins;
            r8_hest <= r7_hest;
            r8_p    <= 11'(r7_hest) * 11'(MINS_PER_HR);
            r8_sec  <= r7_sec;
        end
    end

    // ------------------------------------------------------------ stage 9
    always_comb begin
        s9_diff       = 7'(r8_mins - r8_p);
        n9_tod.second = r8_sec;
        if (s9_diff >= 7'(MINS_PER_HR)) begin
            n9_tod.hour   = r8_hest + 5'd1;
            n9_tod.minute = 6'(s9_diff - 7'(MINS_PER_HR));
        end else begin
            n9_tod.hour   = r8_hest;
            n9_tod.minute = s9_diff[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[9]) begin
            r9_tod <= n9_tod;
        end
    end

    // ---------------------------------------------------- stages 10 to 12
    always_ff @(posedge i_clk) begin
        if (stage_en[10]) begin
            r10_tod <= r9_tod;
        end
        if (stage_en[11]) begin
            r11_tod <= r10_tod;
        end
        if (stage_en[12]) begin
            r12_tod <= r11_tod;
        end
    end

    // Calendar path runs in stages 4 to 12.
    s2cd_date u_date (
        .i_clk  (i_clk),
        .i_en   (stage_en[PIPE_DEPTH:DATE_FIRST]),
        .i_days (r3_days),
        .o_date (date_out)
    );

    // ----------------------------------------------------------- output pack
    assign o_m_tdata = {2'b00, r12_tod.second, r12_tod.minute, r12_tod.hour,
                        date_out.mday, date_out.month, date_out.year};

endmodule
`default_nettype wire

[rtl/s2cd_date.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2cd_date
// Nine-stage calendar path: turns a day count since 2000-01-01 into
// year, month and day of month with the 400/100/4/1-year cycle split.
// ============================================================================
module s2cd_date (
    input  logic                          i_clk,
    input  s2cd_pkg::t_date_en            i_en,
    input  logic [s2cd_pkg::DAYS_W-1:0]   i_days,
    output s2cd_pkg::t_date               o_date
);
    import s2cd_pkg::*;

    // Stage 0: pick the 400-year cycle and the day within it.
    logic        n_d0_hi;
    logic [17:0] n_d0_q;
    logic        r_d0_hi;
    logic [17:0] r_d0_q;

    // Stage 1: century within the cycle.
    logic [2:0]  n_d1_cent;
    logic [15:0] n_d1_rem100;
    logic        r_d1_hi;
    logic [2:0]  r_d1_cent;
    logic [15:0] r_d1_rem100;

    // Stage 2: estimate of the 4-year block.
    logic [21:0] d2_prod;
    logic        r_d2_hi;
    logic [2:0]  r_d2_cent;
    logic [15:0] r_d2_rem100;
    logic [4:0]  r_d2_n4e;

    // Stage 3: start of the estimated block.
    logic        r_d3_hi;
    logic [2:0]  r_d3_cent;
    logic [15:0] r_d3_rem100;
    logic [4:0]  r_d3_n4e;
    logic [15:0] r_d3_p;

    // Stage 4: corrected block and day within it.
    logic [11:0] d4_diff;
    logic [4:0]  n_d4_n4;
    logic [10:0] n_d4_rem4;
    logic        r_d4_hi;
    logic [2:0]  r_d4_cent;
    logic [4:0]  r_d4_n4;
    logic [10:0] r_d4_rem4;

    // Stage 5: year within block, day of year, leap flag.
    logic [2:0]  d5_yr4;
    logic        d5_last;
    logic [8:0]  n_d5_doy;
    logic        n_d5_leap;
    logic [6:0]  n_d5_low;
    logic        r_d5_hi;
    logic [2:0]  r_d5_cent;
    logic [6:0]  r_d5_low;
    logic [8:0]  r_d5_doy;
    logic        r_d5_leap;

    // Stage 6: year and month numerator.
    logic [1:0]  d6_corr;
    logic [8:0]  d6_x;
    logic [11:0] n_d6_year;
    logic [12:0] n_d6_num;
    t_year       r_d6_year;
    logic [12:0] r_d6_num;
    logic [8:0]  r_d6_doy;
    logic [1:0]  r_d6_corr;

    // Stage 7: month.
    t_month      n_d7_month;
    logic [1:0]  n_d7_k;
    t_year       r_d7_year;
    t_month      r_d7_month;
    logic [1:0]  r_d7_k;
    logic [8:0]  r_d7_doy;

    // Stage 8: day of month, output register.
    logic [9:0]  d8_mday;
    t_date       r_d8_date;

    // ---------------------------------------------------------------- stage 0
    always_comb begin
        n_d0_hi = (i_days >= 16'(DN_SPLIT));
        if (n_d0_hi) begin
            n_d0_q = 18'(i_days) - 18'(DN_SPLIT);
        end else begin
            n_d0_q = 18'(i_days) + 18'(DN_OFF_LO);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d0_hi <= n_d0_hi;
            r_d0_q  <= n_d0_q;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // The century count is the number of century bounds passed.
    always_comb begin
        n_d1_cent = '0;
        for (int j = 1; j <= CYCLE_LAST; j++) begin
            if (r_d0_q >= 18'(j * DAYS_100Y)) begin
                n_d1_cent = n_d1_cent + 3'd1;
            end
        end
        n_d1_rem100 = 16'(r_d0_q - 18'(int'(n_d1_cent) * DAYS_100Y));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_d1_hi     <= r_d0_hi;
            r_d1_cent   <= n_d1_cent;
            r_d1_rem100 <= n_d1_rem100;
        end
    end

    // ---------------------------------------------------------------- stage 2
    assign d2_prod = 22'(r_d1_rem100) * 22'(Q4Y_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_d2_hi     <= r_d1_hi;
            r_d2_cent   <= r_d1_cent;
            r_d2_rem100 <= r_d1_rem100;
            r_d2_n4e    <= d2_prod[20:16];
        end
    end

    // ---------------------------------------------------------------- stage 3
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_d3_hi     <= r_d2_hi;
            r_d3_cent   <= r_d2_cent;
            r_d3_rem100 <= r_d2_rem100;
            r_d3_n4e    <= r_d2_n4e;
            r_d3_p      <= 16'(r_d2_n4e) * 16'(DAYS_4Y);
        end
    end

    // ---------------------------------------------------------------- stage 4
    // The estimate may be one block short; fix it with one subtract.
    always_comb begin
        d4_diff = 12'(r_d3_rem100 - r_d3_p);
        if (d4_diff >= 12'(DAYS_4Y)) begin
            n_d4_n4   = r_d3_n4e + 5'd1;
            n_d4_rem4 = 11'(d4_diff - 12'(DAYS_4Y));
        end else begin
            n_d4_n4   = r_d3_n4e;
            n_d4_rem4 = d4_diff[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_d4_hi   <= r_d3_hi;
            r_d4_cent <= r_d3_cent;
            r_d4_n4   <= n_d4_n4;
            r_d4_rem4 <= n_d4_rem4;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // On the last day of a 400-year cycle or a 4-year block the year count
    // stays and the day is December 31 of a leap year.
    always_comb begin
        d5_yr4 = '0;
        for (int j = 1; j <= CYCLE_LAST; j++) begin
            if (r_d4_rem4 >= 11'(j * DAYS_1Y)) begin
                d5_yr4 = d5_yr4 + 3'd1;
            end
        end
        d5_last = (r_d4_cent == 3'(CYCLE_LAST)) || (d5_yr4 == 3'(CYCLE_LAST));
        if (d5_last) begin
            n_d5_doy = 9'(DAYS_1Y);
        end else begin
            n_d5_doy = 9'(r_d4_rem4 - 11'(int'(d5_yr4) * DAYS_1Y));
        end
        // A year ending a block is leap unless it ends a century that is
        // not the last one of the 400-year cycle.
        n_d5_leap = d5_last
                 || ((d5_yr4 == 3'(YR4_LEAP))
                     && ((r_d4_n4 != 5'(N4_LAST)) || (r_d4_cent == 3'(CENT_LAST))));
        n_d5_low  = {r_d4_n4, 2'b00} + 7'(d5_yr4) + 7'(!d5_last);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_d5_hi   <= r_d4_hi;
            r_d5_cent <= r_d4_cent;
            r_d5_low  <= n_d5_low;
            r_d5_doy  <= n_d5_doy;
            r_d5_leap <= n_d5_leap;
        end
    end

    // ---------------------------------------------------------------- stage 6
    always_comb begin
        d6_corr = r_d5_leap ? 2'd1 : 2'd2;
        if ((10'(r_d5_doy) + 10'(d6_corr)) < 10'(MARCH_DOY)) begin
            d6_x = r_d5_doy;
        end else begin
            d6_x = r_d5_doy + 9'(d6_corr);
        end
        n_d6_num  = 13'(d6_x) * 13'(MONTH_MUL) + 13'(MONTH_ADD);
        n_d6_year = 12'(r_d5_hi ? YEAR_BASE_HI : YEAR_BASE_LO)
                  + 12'(int'(r_d5_cent) * 100) + 12'(r_d5_low);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_d6_year <= n_d6_year;
            r_d6_num  <= n_d6_num;
            r_d6_doy  <= r_d5_doy;
            r_d6_corr <= d6_corr;
        end
    end

    // ---------------------------------------------------------------- stage 7
    // Month is the numerator divided by 367, counted over the twelve bounds.
    always_comb begin
        n_d7_month = '0;
        for (int j = 1; j <= MONTH_MUL; j++) begin
            if (r_d6_num >= 13'(j * MONTH_DIV)) begin
                n_d7_month = n_d7_month + 4'd1;
            end
        end
        n_d7_k = (n_d7_month <= 4'd2) ? 2'd0 : r_d6_corr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_d7_year  <= r_d6_year;
            r_d7_month <= n_d7_month;
            r_d7_k     <= n_d7_k;
            r_d7_doy   <= r_d6_doy;
        end
    end

    // ---------------------------------------------------------------- stage 8
    assign d8_mday = 10'(r_d7_doy) + 10'(r_d7_k) + 10'd1 - 10'(month_start(r_d7_month));

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_d8_date.year  <= r_d7_year;
            r_d8_date.month <= r_d7_month;
            r_d8_date.mday  <= d8_mday[4:0];
        end
    end

    assign o_date = r_d8_date;

endmodule
`default_nettype wire

[rtl/s2cd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2cd_checker
// Port-level checks for the seconds-to-calendar-date unit, bound to the top.
// ============================================================================
module s2cd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_s_tready,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [s2cd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // A result that is not taken stays offered.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // With the output free, the pipeline always takes a new request.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while output free");

    // Offered results have month 1-12, day nonzero, legal time, zero pad.
    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:12] != 4'd0 && o_m_tdata[15:12] <= 4'd12
                        && o_m_tdata[20:16] != 5'd0 && o_m_tdata[25:21] <= 5'd23
                        && o_m_tdata[31:26] <= 6'd59 && o_m_tdata[37:32] <= 6'd59
                        && o_m_tdata[39:38] == 2'd0))
        else $error("result field out of range");

endmodule

bind seconds_to_calendar_date_unit s2cd_checker u_s2cd_checker (.*);
`default_nettype wire

[verif/tb_seconds_to_calendar_date_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_seconds_to_calendar_date_unit
// Self-checking testbench for the seconds-to-calendar-date pipeline.
// ============================================================================
// Each accepted seconds request is converted by an in-bench calendar model,
// and the expected date and time are queued. Every result request that
// leaves the block is compared field by field with the oldest entry. The
// tests cover directed boundary dates, uniform random counts, random counts
// near day, month and year edges, back-to-back traffic, and a long output
// stall that fills the pipeline and pushes back on the input.
// ============================================================================
module tb_seconds_to_calendar_date_unit;

    // Expected content of one result request, plus the count that caused it.
    typedef struct {
        logic [31:0]       secs;
        s2cd_pkg::t_year   year;
        s2cd_pkg::t_month  month;
        s2cd_pkg::t_mday   mday;
        s2cd_pkg::t_hour   hour;
        s2cd_pkg::t_minute minute;
        s2cd_pkg::t_second second;
    } t_cal_fields;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;     // [31:0] seconds_since_epoch
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    logic [39:0] o_m_tdata;

    t_cal_fields pending_dates[$];
    int          n_fail        = 0;
    bit          tx_no_idle    = 1'b0;
    bit          rx_no_idle    = 1'b0;
    int          rx_hold_off   = 0;
    int          rx_stall_left = 0;

    seconds_to_calendar_date_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Calendar model: day split, 400/100/4/1-year cycles, then month formula.
    function automatic t_cal_fields seconds_to_date(input logic [31:0] secs);
        longint unsigned days, sod, dn, q, cent, rem100, yr4, yr, z, doy;
        longint unsigned corr, adj, mon, k, mday;
        bit              leap;
        t_cal_fields     r;
        days   = secs / 86400;
        sod    = secs % 86400;
        dn     = days + 730119;
        q      = dn % 146097;
        cent   = q / 36524;
        rem100 = q % 36524;
        yr4    = (rem100 % 1461) / 365;
        yr     = (dn / 146097) * 400 + cent * 100 + (rem100 / 1461) * 4 + yr4
               + ((cent == 4 || yr4 == 4) ? 0 : 1);
        z      = yr - 1;
        doy    = dn - 365 * z - z / 4 + z / 100 - z / 400;
        leap   = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        corr   = leap ? 1 : 2;
        adj    = (doy + corr < 61) ? 0 : corr;
        mon    = ((doy + adj) * 12 + 373) / 367;
        k      = (mon <= 2) ? 0 : corr;
        mday   = doy + k + 1 - (367 * mon - 362) / 12;
        r.secs   = secs;
        r.year   = yr[11:0];
        r.month  = mon[3:0];
        r.mday   = mday[4:0];
        r.hour   = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.second = 6'(sod % 60);
        return r;
    endfunction

    // Day count (from 2000-01-01) of January 1 of the given year.
    function automatic longint year_start_day(input int y);
        longint n;
        n = y - 1;
        return 365 * n + n / 4 - n / 100 + n / 400 - 730119;
    endfunction

    function automatic logic [31:0] secs_at(input longint day, input longint tod);
        longint s;
        s = day * 86400 + tod;
        return s[31:0];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one seconds request and queue its expected date once accepted.
    // Valid stays high afterward so a following request can go back to back.
    task automatic send_seconds(input logic [31:0] secs);
        int gap;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= secs;
        do @(posedge i_clk); while (!o_s_tready);
        pending_dates.push_back(seconds_to_date(secs));
    endtask

    // Receiver: random stalls, plus a long hold-off on demand.
    always @(posedge i_clk) begin
        if (rx_hold_off > 0) begin
            rx_hold_off--;
            i_m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (!rx_no_idle) rx_stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [31:0] secs,
                               input logic [11:0] want, input logic [11:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch for %0d s: expected %0d, actual %0d",
                     $time, name, secs, want, got);
            n_fail++;
        end
    endtask

    // Compare every accepted result request with the oldest expectation.
    always @(posedge i_clk) begin : chk_results
        t_cal_fields want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected result request, tdata %h", $time, o_m_tdata);
                n_fail++;
            end else begin
                want = pending_dates.pop_front();
                check_field("year",   want.secs, 12'(want.year),   12'(o_m_tdata[11:0]));
                check_field("month",  want.secs, 12'(want.month),  12'(o_m_tdata[15:12]));
                check_field("day",    want.secs, 12'(want.mday),   12'(o_m_tdata[20:16]));
                check_field("hour",   want.secs, 12'(want.hour),   12'(o_m_tdata[25:21]));
                check_field("minute", want.secs, 12'(want.minute), 12'(o_m_tdata[31:26]));
                check_field("second", want.secs, 12'(want.second), 12'(o_m_tdata[37:32]));
                check_field("pad",    want.secs, 12'd0,            12'(o_m_tdata[39:38]));
            end
        end
    end

    // Extremes of the count, day and hour edges, leap days, and the two
    // end-of-cycle cases where December 31 of a leap year gets no extra year.
    task automatic test_directed_boundaries();
        send_seconds(32'd0);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
        send_seconds(secs_at(58, 86399));                    // 2000-02-28
        send_seconds(secs_at(59, 0));                        // 2000-02-29
        send_seconds(secs_at(60, 0));                        // 2000-03-01
        send_seconds(secs_at(365, 86399));                   // end of 400-year cycle
        send_seconds(secs_at(366, 0));
        send_seconds(secs_at(year_start_day(2005) - 1, 86399)); // end of 4-year block
        send_seconds(secs_at(year_start_day(2005), 0));
        send_seconds(secs_at(year_start_day(2100) + 58, 86399)); // 2100 is not leap
        send_seconds(secs_at(year_start_day(2100) + 59, 0));
        send_seconds(secs_at(year_start_day(2101) - 1, 43200));
        send_seconds(32'h7FFF_FFFF);
        send_seconds(32'h8000_0000);
        send_seconds(32'h5555_5555);
        send_seconds(32'hAAAA_AAAA);
        send_seconds(32'hFFFF_FFFE);
        send_seconds(32'hFFFF_FFFF);
    endtask

    task automatic test_random_full_range();
        repeat (320) send_seconds($urandom);
    endtask

    // Random years, landing mostly on year ends, leap days and day edges.
    task automatic test_random_calendar_edges();
        int     y;
        longint day, tod, s;
        repeat (320) begin
            y = $urandom_range(2000, 2136);
            case ($urandom_range(0, 5))
                0:       day = year_start_day(y) - 1;
                1:       day = year_start_day(y);
                2:       day = year_start_day(y) + 58;
                3:       day = year_start_day(y) + 59;
                4:       day = year_start_day(y) + 60;
                default: day = $urandom_range(0, 49710);
            endcase
            case ($urandom_range(0, 3))
                0:       tod = 0;
                1:       tod = 86399;
                2:       tod = $urandom_range(0, 86399);
                default: tod = 3600 * $urandom_range(0, 23) + 60 * $urandom_range(0, 59) + 59;
            endcase
            s = day * 86400 + tod;
            if (day < 0 || s > 64'hFFFF_FFFF) s = $urandom;
            send_seconds(s[31:0]);
        end
    endtask

    // No idling on either side: one request per cycle while o_s_tready is high.
    task automatic test_back_to_back();
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        repeat (100) send_seconds($urandom);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input.
    task automatic test_output_hold_off();
        rx_hold_off = 400;
        tx_no_idle  = 1'b1;
        repeat (60) send_seconds($urandom);
        tx_no_idle  = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_boundaries();
        test_random_full_range();
        test_output_hold_off();
        test_random_calendar_edges();
        test_back_to_back();

        i_s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);

        if (n_fail == 0 && pending_dates.size() == 0) begin
            $display("seconds_to_calendar_date_unit regression: pass");
        end else begin
            $display("seconds_to_calendar_date_unit regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, pending_dates.size());
        $display("seconds_to_calendar_date_unit regression: fail");
        $finish;
    end

endmodule
